FILE: design/tets_pkg.sv
`default_nettype none

package tets_pkg;

    localparam int EVENT_SLOTS_DEF = 64;
    localparam int LIMIT_W         = 9;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd32;

    localparam logic [2:0] REQ_ON     = 3'd0;
    localparam logic [2:0] REQ_OFF    = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_RANDOM = 3'd3;
    localparam logic [2:0] REQ_TICK   = 3'd4;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_ON   = 2'd1;
    localparam logic [1:0] KIND_OFF  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [1:0] STS_OK     = 2'd0;
    localparam logic [1:0] STS_BOUNDS = 2'd1;
    localparam logic [1:0] STS_FULL   = 2'd2;

    localparam logic [3:0] DAY_SUN     = 4'd0;
    localparam logic [3:0] DAY_MON     = 4'd1;
    localparam logic [3:0] DAY_FRI     = 4'd5;
    localparam logic [3:0] DAY_SAT     = 4'd6;
    localparam logic [3:0] DAY_ALL     = 4'd7;
    localparam logic [3:0] DAY_WEEKDAY = 4'd8;
    localparam logic [3:0] DAY_WEEKEND = 4'd9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // one slot of the event table, msb first
    typedef struct packed {
        logic [6:0]  ofs;
        logic        rnd;
        logic [10:0] minute;
        logic [3:0]  day;
        logic        on;
        logic [7:0]  light;
    } entry_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic proc_en;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
        logic stall;
        logic out_free;
    } dp_sts_t;

    function automatic logic day_match(input logic [3:0] d, input logic [3:0] today);
        logic hit;
        hit = (d == DAY_ALL) || (d == today);
        if (d == DAY_WEEKEND && (today == DAY_SUN || today == DAY_SAT))
            hit = 1'b1;
        if (d == DAY_WEEKDAY && today >= DAY_MON && today <= DAY_FRI)
            hit = 1'b1;
        return hit;
    endfunction

endpackage

`default_nettype wire

FILE: design/tets_ctrl.sv
`default_nettype none

module tets_ctrl #(
    parameter int EVENT_SLOTS = tets_pkg::EVENT_SLOTS_DEF,
    parameter int IW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1,
    parameter int CW = $clog2(EVENT_SLOTS + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire tets_pkg::dp_sts_t sts,
    output tets_pkg::dp_cmd_t     cmd,
    output logic [IW-1:0]         rd_addr,
    output logic [IW-1:0]         proc_idx
);

    tets_pkg::state_t state_reg, state_next;
    logic [CW-1:0] rd_cnt_reg, rd_cnt_next;
    logic          p1_valid_reg, p1_valid_next;
    logic [IW-1:0] p1_idx_reg, p1_idx_next;

    logic advance;
    logic rd_issue;

    // stage 1 holds when a fired slot has nowhere to put the previous command
    assign advance  = !(p1_valid_reg && sts.stall);
    assign rd_issue = (state_reg == tets_pkg::ST_SCAN) && advance && !sts.skip
                      && (rd_cnt_reg < CW'(EVENT_SLOTS));

    always_comb
    begin
        state_next    = state_reg;
        rd_cnt_next   = rd_cnt_reg;
        p1_valid_next = p1_valid_reg;
        p1_idx_next   = p1_idx_reg;
        case (state_reg)
            tets_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next    = tets_pkg::ST_SCAN;
                    rd_cnt_next   = '0;
                    p1_valid_next = 1'b0;
                end
            end
            tets_pkg::ST_SCAN:
            begin
                if (advance)
                begin
                    p1_valid_next = rd_issue;
                    p1_idx_next   = rd_cnt_reg[IW-1:0];
                    rd_cnt_next   = rd_cnt_reg + CW'(rd_issue);
                    if (!rd_issue)
                        state_next = tets_pkg::ST_DONE;
                end
            end
            tets_pkg::ST_DONE:
            begin
                if (sts.out_free)
                    state_next = tets_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tets_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            tets_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            tets_pkg::ST_SCAN:
            begin
                cmd.rd_en   = rd_issue;
                cmd.proc_en = p1_valid_reg && advance;
            end
            tets_pkg::ST_DONE:
            begin
                cmd.emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign rd_addr  = rd_cnt_reg[IW-1:0];
    assign proc_idx = p1_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tets_pkg::ST_IDLE;
            rd_cnt_reg   <= '0;
            p1_valid_reg <= 1'b0;
            p1_idx_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            p1_valid_reg <= p1_valid_next;
            p1_idx_reg   <= p1_idx_next;
        end
    end

    a_p1_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg |-> (state_reg == tets_pkg::ST_SCAN))
        else $error("stage 1 busy outside scan");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rd_cnt_reg <= CW'(EVENT_SLOTS))
        else $error("slot counter past table end");

endmodule

`default_nettype wire

FILE: design/tets_dp.sv
`default_nettype none

module tets_dp #(
    parameter int EVENT_SLOTS = tets_pkg::EVENT_SLOTS_DEF,
    parameter int IW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    input  wire logic [tets_pkg::LIMIT_W-1:0] cfg_data,
    input  wire logic [2:0]                   req_type,
    input  wire logic [7:0]                   light_id,
    input  wire logic [3:0]                   day_code,
    input  wire logic [10:0]                  minute_of_day,
    input  wire logic [6:0]                   random_offset,
    input  wire tets_pkg::dp_cmd_t            cmd,
    input  wire logic [IW-1:0]                rd_addr,
    input  wire logic [IW-1:0]                proc_idx,
    output tets_pkg::dp_sts_t                 sts,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [1:0]                        out_kind,
    output logic [1:0]                        out_status,
    output logic [7:0]                        out_light,
    output logic                              out_last
);

    logic [tets_pkg::LIMIT_W-1:0] limit_reg;

    logic [2:0]  req_reg;
    logic [7:0]  id_reg;
    logic [3:0]  day_reg;
    logic [10:0] min_reg;
    logic [6:0]  rnd_reg;
    logic        oob_reg;
    logic        found_reg, found_next;

    logic        pend_valid_reg, pend_valid_next;
    logic [1:0]  pend_kind_reg, pend_kind_next;
    logic [7:0]  pend_light_reg, pend_light_next;

    logic [EVENT_SLOTS-1:0] valid_reg, valid_next;

    tets_pkg::entry_t mem [EVENT_SLOTS];
    tets_pkg::entry_t mem_q_reg;
    tets_pkg::entry_t wr_data;
    logic             wr_en;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [7:0]  out_light_reg, out_light_next;
    logic        out_last_reg, out_last_next;

    logic        is_sched;
    logic        is_tick;
    logic        known_req;
    logic        slot_live;
    logic        key_hit;
    logic [12:0] due;
    logic        fire;
    logic        out_free;
    logic        push_pend;
    logic [1:0]  fire_kind;
    logic [1:0]  final_status;

    assign is_sched  = (req_reg == tets_pkg::REQ_ON) || (req_reg == tets_pkg::REQ_OFF);
    assign is_tick   = (req_reg == tets_pkg::REQ_TICK);
    assign known_req = req_reg inside {tets_pkg::REQ_ON, tets_pkg::REQ_OFF,
                                       tets_pkg::REQ_REMOVE, tets_pkg::REQ_RANDOM,
                                       tets_pkg::REQ_TICK};

    assign slot_live = valid_reg[proc_idx];
    assign key_hit   = (mem_q_reg.light == id_reg) && (mem_q_reg.day == day_reg)
                       && (mem_q_reg.minute == min_reg);
    // minute plus signed offset, no wrap; 13 bits cannot overflow
    assign due  = {2'b00, mem_q_reg.minute} + {{6{mem_q_reg.ofs[6]}}, mem_q_reg.ofs};
    assign fire = slot_live && tets_pkg::day_match(mem_q_reg.day, day_reg)
                  && (due == {2'b00, min_reg});
    assign fire_kind = mem_q_reg.on ? tets_pkg::KIND_ON : tets_pkg::KIND_OFF;

    assign out_free  = !out_valid_reg || out_ready;
    assign push_pend = cmd.proc_en && is_tick && fire && pend_valid_reg;

    assign sts.skip     = (is_sched && oob_reg) || !known_req;
    assign sts.stall    = is_tick && fire && pend_valid_reg && !out_free;
    assign sts.out_free = out_free;

    always_comb
    begin
        wr_en           = 1'b0;
        wr_data         = mem_q_reg;
        valid_next      = valid_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_light_next = pend_light_reg;
        if (cmd.load)
        begin
            found_next      = 1'b0;
            pend_valid_next = 1'b0;
        end
        else if (cmd.proc_en)
        begin
            case (req_reg)
                tets_pkg::REQ_ON, tets_pkg::REQ_OFF:
                begin
                    if (!slot_live && !found_reg)
                    begin
                        wr_en          = 1'b1;
                        wr_data        = '0;
                        wr_data.light  = id_reg;
                        wr_data.on     = (req_reg == tets_pkg::REQ_ON);
                        wr_data.day    = day_reg;
                        wr_data.minute = min_reg;
                        valid_next[proc_idx] = 1'b1;
                        found_next     = 1'b1;
                    end
                end
                tets_pkg::REQ_REMOVE:
                begin
                    if (slot_live && key_hit)
                        valid_next[proc_idx] = 1'b0;
                end
                tets_pkg::REQ_RANDOM:
                begin
                    if (slot_live && key_hit)
                    begin
                        wr_en       = 1'b1;
                        wr_data.rnd = 1'b1;
                        wr_data.ofs = rnd_reg;
                    end
                end
                tets_pkg::REQ_TICK:
                begin
                    if (fire)
                    begin
                        wr_en           = 1'b1;
                        wr_data.ofs     = mem_q_reg.rnd ? rnd_reg : 7'd0;
                        pend_valid_next = 1'b1;
                        pend_kind_next  = fire_kind;
                        pend_light_next = mem_q_reg.light;
                    end
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        else if (cmd.emit)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        if (!is_sched)
            final_status = tets_pkg::STS_OK;
        else if (oob_reg)
            final_status = tets_pkg::STS_BOUNDS;
        else if (found_reg)
            final_status = tets_pkg::STS_OK;
        else
            final_status = tets_pkg::STS_FULL;
    end

    // the newest fired command waits in pend until we know whether it is last
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_light_next  = out_light_reg;
        out_last_next   = out_last_reg;
        if (push_pend)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = pend_kind_reg;
            out_status_next = tets_pkg::STS_OK;
            out_light_next  = pend_light_reg;
            out_last_next   = 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b1;
            if (pend_valid_reg)
            begin
                out_kind_next   = pend_kind_reg;
                out_status_next = tets_pkg::STS_OK;
                out_light_next  = pend_light_reg;
            end
            else
            begin
                out_kind_next   = is_tick ? tets_pkg::KIND_NONE : tets_pkg::KIND_ACK;
                out_status_next = final_status;
                out_light_next  = 8'd0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= tets_pkg::LIMIT_RESET;
            valid_reg      <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                limit_reg <= cfg_data;
            valid_reg      <= valid_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_type;
            id_reg  <= light_id;
            day_reg <= day_code;
            min_reg <= minute_of_day;
            rnd_reg <= random_offset;
            oob_reg <= ({1'b0, light_id} >= limit_reg);
        end
        pend_kind_reg  <= pend_kind_next;
        pend_light_reg <= pend_light_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_light_reg  <= out_light_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[proc_idx] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            mem_q_reg <= mem[rd_addr];
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_status = out_status_reg;
    assign out_light  = out_light_reg;
    assign out_last   = out_last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (push_pend || cmd.emit) |-> out_free)
        else $error("result word overwritten before taken");

    a_pend_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && !cmd.load) |-> is_tick)
        else $error("pending command outside a tick");

    a_one_sched_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.proc_en && is_sched && found_reg) |-> !wr_en)
        else $error("schedule wrote a second slot");

endmodule

`default_nettype wire

FILE: design/timed_event_table_scheduler.sv
// channel  direction  handshake                 payload
// s_*      in         s_tvalid / s_tready       tuser req_type, tdata request fields
// m_*      out        m_tvalid / m_tready       tuser result_kind, tdata, tlast
// cfg_*    in         cfg_valid / cfg_ready     cfg_data light_limit
//
// Every request scans the slot table, one slot per cycle over EVENT_SLOTS slots
// through the table memory's single read port, unless the result port stalls the scan.
// Schedule requests with an out-of-range light and unknown requests skip the scan.
// A stalled result port holds the scan only when a second fired command needs room.
// Reset clears the valid bits and loads light_limit (32) at once; no clearing pass.
`default_nettype none

module timed_event_table_scheduler #(
    parameter int EVENT_SLOTS = tets_pkg::EVENT_SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // light_id[7:0], day_code[11:8],
                                        // minute_of_day[22:12], random_offset[29:23]
    input  wire logic [2:0]  s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // status[1:0], light_out[9:2]
    output logic [1:0]       m_tuser,   // result_kind
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data
);

    localparam int IW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int CW = $clog2(EVENT_SLOTS + 1);

    tets_pkg::dp_cmd_t cmd;
    tets_pkg::dp_sts_t sts;
    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     proc_idx;
    logic [1:0]        status;
    logic [7:0]        light_out;

    assign cfg_ready = 1'b1;

    tets_ctrl #(
        .EVENT_SLOTS (EVENT_SLOTS),
        .IW          (IW),
        .CW          (CW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .proc_idx (proc_idx)
    );

    tets_dp #(
        .EVENT_SLOTS (EVENT_SLOTS),
        .IW          (IW)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .req_type      (s_tuser),
        .light_id      (s_tdata[7:0]),
        .day_code      (s_tdata[11:8]),
        .minute_of_day (s_tdata[22:12]),
        .random_offset (s_tdata[29:23]),
        .cmd           (cmd),
        .rd_addr       (rd_addr),
        .proc_idx      (proc_idx),
        .sts           (sts),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_kind      (m_tuser),
        .out_status    (status),
        .out_light     (light_out),
        .out_last      (m_tlast)
    );

    assign m_tdata = {6'd0, light_out, status};

endmodule

`default_nettype wire
